[design/hrd_pkg.sv]
// Shared constants, register codes and controller/datapath interface types
// for the PPG heart-rate detector. No dependencies.
package hrd_pkg;

    localparam int SAMPLE_WIDTH_DEFAULT = 16;
    localparam int COUNT_WIDTH_DEFAULT  = 16;

    localparam int RATE_WIDTH   = 16;
    localparam int FALL_WIDTH   = 16;
    localparam int STRONG_WIDTH = 17;
    localparam int CFG_ADDR_WIDTH = 2;
    localparam int CFG_DATA_WIDTH = 17;

    localparam logic [FALL_WIDTH-1:0]   FALL_THRESHOLD_RESET = 16'd20;
    localparam logic [STRONG_WIDTH-1:0] STRONG_LEVEL_RESET   = 17'd50;
    localparam logic [RATE_WIDTH-1:0]   RATE_NUMERATOR_RESET = 16'd1200;

    // Low-pass coefficients in Q0.16.
    localparam logic [16:0] K_IN = 17'd16072;
    localparam logic [16:0] K_FB = 17'd33392;

    // Division by five as a multiply by ceil(2^26 / 5) and a shift by 26; the
    // result is exact for every magnitude below 2^26.
    localparam int                         AVG_RECIP_WIDTH = 24;
    localparam logic [AVG_RECIP_WIDTH-1:0] AVG_RECIP       = 24'd13421773;
    localparam int                         AVG_SHIFT       = 26;

    typedef enum logic [CFG_ADDR_WIDTH-1:0] {
        CFG_FALL_THRESHOLD = 2'd0,
        CFG_STRONG_LEVEL   = 2'd1,
        CFG_RATE_NUMERATOR = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic dc_step;    // sample accepted: DC stage and tap shift
        logic sum_load;   // register the five-tap sum
        logic avg_load;   // register the five-tap average
        logic div_start;  // start the rate divider
        logic mul_in;     // first low-pass product
        logic mul_fb;     // feedback product and sum
        logic detect;     // beat detector update
        logic load_out;   // load the output register
    } hrd_cmd_t;

    typedef struct packed {
        logic div_busy;
    } hrd_status_t;

endpackage

[design/hrd_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
// Depends on nothing; used by hrd_datapath.
module hrd_div #(
    parameter int DIVIDEND_WIDTH = 21,
    parameter int DIVISOR_WIDTH  = 16,
    parameter int STEP_WIDTH     = $clog2(DIVIDEND_WIDTH + 1)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [STEP_WIDTH-1:0]     steps,
    input  logic [DIVIDEND_WIDTH-1:0] dividend,
    input  logic [DIVISOR_WIDTH-1:0]  divisor,
    output logic                      busy,
    output logic [DIVIDEND_WIDTH-1:0] quotient
);

    logic                      busy_reg, busy_next;
    logic [STEP_WIDTH-1:0]     cnt_reg, cnt_next;
    logic [DIVIDEND_WIDTH-1:0] quo_reg, quo_next;
    logic [DIVISOR_WIDTH-1:0]  rem_reg, rem_next;
    logic [DIVISOR_WIDTH-1:0]  dsr_reg, dsr_next;
    logic [DIVISOR_WIDTH:0]    trial;
    logic [DIVISOR_WIDTH:0]    diff;
    logic                      fits;

    // The dividend is shifted out from its top bit while quotient bits enter below.
    assign trial = {rem_reg, quo_reg[DIVIDEND_WIDTH-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fits  = (trial >= {1'b0, dsr_reg});

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = steps;
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DIVIDEND_WIDTH-2:0], fits};
            rem_next = fits ? diff[DIVISOR_WIDTH-1:0] : trial[DIVISOR_WIDTH-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == STEP_WIDTH'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

[design/hrd_datapath.sv]
// Datapath of the heart-rate detector: DC removal, moving average, low-pass,
// beat detector and rate division. Depends on hrd_pkg and hrd_div.
module hrd_datapath #(
    parameter int SAMPLE_WIDTH = hrd_pkg::SAMPLE_WIDTH_DEFAULT,
    parameter int COUNT_WIDTH  = hrd_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  hrd_pkg::hrd_cmd_t                     cmd,
    output hrd_pkg::hrd_status_t                  status,
    input  logic [SAMPLE_WIDTH-1:0]               ir_sample,
    input  logic [hrd_pkg::FALL_WIDTH-1:0]        fall_threshold,
    input  logic [hrd_pkg::STRONG_WIDTH-1:0]      strong_level,
    input  logic [hrd_pkg::RATE_WIDTH-1:0]        rate_numerator,
    output logic [hrd_pkg::RATE_WIDTH-1:0]        heart_rate,
    output logic                                  rate_valid,
    output logic                                  beat_ended,
    output logic                                  in_beat,
    output logic                                  strong_beat,
    output logic signed [SAMPLE_WIDTH+1:0]        filtered_value
);

    localparam int ACC_W  = SAMPLE_WIDTH + 2;
    localparam int Y_W    = ACC_W + 1;
    localparam int SUM_W  = ACC_W + 4;
    localparam int MAG_W  = ACC_W + 3;
    localparam int AVG_W  = ACC_W + 2;
    localparam int PROD_W = AVG_W + 18;
    localparam int RCP_W  = MAG_W + hrd_pkg::AVG_RECIP_WIDTH;
    localparam int DIV_DW = hrd_pkg::RATE_WIDTH;
    localparam int DIV_VW = COUNT_WIDTH;
    localparam int DIV_SW = $clog2(DIV_DW + 1);
    localparam int CMP_W  = ((ACC_W > hrd_pkg::STRONG_WIDTH) ? ACC_W : hrd_pkg::STRONG_WIDTH) + 2;
    localparam int NTAPS  = 5;

    localparam logic signed [PROD_W-1:0] FILT_MAX = PROD_W'((2 ** (ACC_W - 1)) - 1);
    localparam logic signed [PROD_W-1:0] FILT_MIN = -FILT_MAX - PROD_W'(1);
    localparam logic signed [PROD_W-1:0] ROUND_ADJ = PROD_W'(65535);

    // Filter and detector state.
    logic [ACC_W-1:0]              dc_acc_reg;
    logic signed [Y_W-1:0]         tap_reg [NTAPS];
    logic signed [SUM_W-1:0]       sum_reg;
    logic signed [AVG_W-1:0]       avg_reg;
    logic signed [PROD_W-1:0]      prod_reg;
    logic signed [PROD_W-1:0]      lp_sum_reg;
    logic signed [ACC_W-1:0]       prev_filt_reg;
    logic                          beat_flag_reg;
    logic [COUNT_WIDTH-1:0]        cnt_reg;
    logic [COUNT_WIDTH-1:0]        period_reg;
    logic                          ended_reg;
    logic                          strong_reg;

    // Output register.
    logic [hrd_pkg::RATE_WIDTH-1:0] rate_out_reg;
    logic                           valid_out_reg;
    logic                           ended_out_reg;
    logic                           beat_out_reg;
    logic                           strong_out_reg;
    logic signed [ACC_W-1:0]        filt_out_reg;

    // DC removal: 0.75 * w is taken as (3 * w) >> 2, rounded down.
    logic [ACC_W+1:0]      dc_fb3;
    logic [ACC_W-1:0]      dc_fb;
    logic [ACC_W:0]        w_sum;
    logic [ACC_W-1:0]      w_new;
    logic signed [Y_W-1:0] y_new;

    assign dc_fb3 = {2'b00, dc_acc_reg} + {1'b0, dc_acc_reg, 1'b0};
    assign dc_fb  = dc_fb3[ACC_W+1:2];
    assign w_sum  = (ACC_W + 1)'(ir_sample) + {1'b0, dc_fb};
    assign w_new  = w_sum[ACC_W] ? {ACC_W{1'b1}} : w_sum[ACC_W-1:0];
    assign y_new  = $signed({1'b0, w_new}) - $signed({1'b0, dc_acc_reg});

    // Five-tap sum; the newest tap is the last one.
    logic signed [SUM_W-1:0] tap_sum;
    assign tap_sum = SUM_W'(tap_reg[0]) + SUM_W'(tap_reg[1]) + SUM_W'(tap_reg[2])
                   + SUM_W'(tap_reg[3]) + SUM_W'(tap_reg[4]);

    logic                    sum_neg;
    logic [SUM_W-1:0]        sum_abs;
    assign sum_neg = sum_reg[SUM_W-1];
    assign sum_abs = sum_neg ? -sum_reg : sum_reg;

    // Average, truncated toward zero by dividing the magnitude by five.
    logic [RCP_W-1:0]        avg_prod;
    logic [AVG_W-2:0]        avg_mag;
    logic signed [AVG_W-1:0] avg_next;
    assign avg_prod = RCP_W'(sum_abs[MAG_W-1:0]) * RCP_W'(hrd_pkg::AVG_RECIP);
    assign avg_mag  = avg_prod[hrd_pkg::AVG_SHIFT +: AVG_W-1];
    assign avg_next = sum_neg ? -$signed({1'b0, avg_mag}) : $signed({1'b0, avg_mag});

    // Rate divider: numerator by latched period.
    logic              div_busy;
    logic [DIV_DW-1:0] div_quo;
    logic [DIV_DW-1:0] div_dividend;
    logic [DIV_VW-1:0] div_divisor;
    logic [DIV_SW-1:0] div_steps;

    assign div_dividend = rate_numerator;
    assign div_divisor  = period_reg;
    assign div_steps    = DIV_SW'(hrd_pkg::RATE_WIDTH);

    hrd_div #(
        .DIVIDEND_WIDTH (DIV_DW),
        .DIVISOR_WIDTH  (DIV_VW),
        .STEP_WIDTH     (DIV_SW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .steps    (div_steps),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    assign status.div_busy = div_busy;

    // One multiplier serves both low-pass products.
    logic signed [AVG_W-1:0]  mul_a;
    logic [16:0]              mul_k;
    logic signed [PROD_W-1:0] mul_p;
    assign mul_a = cmd.mul_fb ? AVG_W'(prev_filt_reg) : avg_reg;
    assign mul_k = cmd.mul_fb ? hrd_pkg::K_FB : hrd_pkg::K_IN;
    assign mul_p = mul_a * $signed({1'b0, mul_k});

    // Divide by 2^16 toward zero, then saturate.
    logic signed [PROD_W-1:0] lp_adj;
    logic signed [PROD_W-1:0] lp_shift;
    logic signed [ACC_W-1:0]  filt;
    assign lp_adj   = lp_sum_reg + (lp_sum_reg[PROD_W-1] ? ROUND_ADJ : PROD_W'(0));
    assign lp_shift = lp_adj >>> 16;

    always_comb
    begin
        priority if (lp_shift > FILT_MAX)
            filt = FILT_MAX[ACC_W-1:0];
        else if (lp_shift < FILT_MIN)
            filt = FILT_MIN[ACC_W-1:0];
        else
            filt = lp_shift[ACC_W-1:0];
    end

    // Beat detector.
    logic signed [CMP_W-1:0] filt_c, prev_c, thr_c, lvl_c;
    logic                    flag_set, beat_end, flag_new, strong_new;
    logic [COUNT_WIDTH-1:0]  cnt_base, cnt_new, period_new;

    assign filt_c     = CMP_W'(filt);
    assign prev_c     = CMP_W'(prev_filt_reg);
    assign thr_c      = $signed(CMP_W'(fall_threshold));
    assign lvl_c      = $signed(CMP_W'(strong_level));
    assign flag_set   = beat_flag_reg || (filt_c > prev_c);
    assign beat_end   = flag_set && (filt_c <= prev_c - thr_c);
    assign flag_new   = flag_set && !beat_end;
    assign strong_new = flag_new && (filt_c >= lvl_c);
    assign period_new = beat_end ? cnt_reg : period_reg;
    assign cnt_base   = beat_end ? '0 : cnt_reg;
    assign cnt_new    = (cnt_base == {COUNT_WIDTH{1'b1}}) ? cnt_base : cnt_base + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dc_acc_reg    <= '0;
            for (int i = 0; i < NTAPS; i++)
                tap_reg[i] <= '0;
            prev_filt_reg <= '0;
            beat_flag_reg <= 1'b0;
            cnt_reg       <= '0;
            period_reg    <= '0;
        end
        else
        begin
            if (cmd.dc_step)
            begin
                dc_acc_reg <= w_new;
                for (int i = 0; i < NTAPS - 1; i++)
                    tap_reg[i] <= tap_reg[i+1];
                tap_reg[NTAPS-1] <= y_new;
            end
            if (cmd.detect)
            begin
                prev_filt_reg <= filt;
                beat_flag_reg <= flag_new;
                cnt_reg       <= cnt_new;
                period_reg    <= period_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sum_load)
            sum_reg <= tap_sum;
        if (cmd.avg_load)
            avg_reg <= avg_next;
        if (cmd.mul_in)
            prod_reg <= mul_p;
        if (cmd.mul_fb)
            lp_sum_reg <= prod_reg + mul_p;
        if (cmd.detect)
        begin
            ended_reg  <= beat_end;
            strong_reg <= strong_new;
        end
        if (cmd.load_out)
        begin
            rate_out_reg   <= (period_reg != '0) ? div_quo[hrd_pkg::RATE_WIDTH-1:0] : '0;
            valid_out_reg  <= (period_reg != '0);
            ended_out_reg  <= ended_reg;
            beat_out_reg   <= beat_flag_reg;
            strong_out_reg <= strong_reg;
            filt_out_reg   <= prev_filt_reg;
        end
    end

    assign heart_rate     = rate_out_reg;
    assign rate_valid     = valid_out_reg;
    assign beat_ended     = ended_out_reg;
    assign in_beat        = beat_out_reg;
    assign strong_beat    = strong_out_reg;
    assign filtered_value = filt_out_reg;

endmodule

[design/hrd_ctrl.sv]
// Controller state machine of the heart-rate detector: sequences the
// datapath and owns both stream handshakes. Depends on hrd_pkg.
module hrd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output hrd_pkg::hrd_cmd_t    cmd,
    input  hrd_pkg::hrd_status_t status
);

    typedef enum logic [8:0] {
        ST_IDLE       = 9'b0_0000_0001,
        ST_SUM        = 9'b0_0000_0010,
        ST_AVG        = 9'b0_0000_0100,
        ST_MUL_IN     = 9'b0_0000_1000,
        ST_MUL_FB     = 9'b0_0001_0000,
        ST_DETECT     = 9'b0_0010_0000,
        ST_RATE_START = 9'b0_0100_0000,
        ST_RATE_WAIT  = 9'b0_1000_0000,
        ST_OUT        = 9'b1_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_load;

    // The result register may still be waiting for its beat to be taken.
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.dc_step = 1'b1;
                    state_next  = ST_SUM;
                end
            end
            ST_SUM:
            begin
                cmd.sum_load = 1'b1;
                state_next   = ST_AVG;
            end
            ST_AVG:
            begin
                cmd.avg_load = 1'b1;
                state_next   = ST_MUL_IN;
            end
            ST_MUL_IN:
            begin
                cmd.mul_in = 1'b1;
                state_next = ST_MUL_FB;
            end
            ST_MUL_FB:
            begin
                cmd.mul_fb = 1'b1;
                state_next = ST_DETECT;
            end
            ST_DETECT:
            begin
                cmd.detect = 1'b1;
                state_next = ST_RATE_START;
            end
            ST_RATE_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_RATE_WAIT;
            end
            ST_RATE_WAIT:
            begin
                if (!status.div_busy)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (out_load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

[design/pulse_oximeter_heart_rate_detector_top.sv]
// A new sample is taken only in the idle state, after the previous result has been
// loaded into the output register. The bit-serial rate divider takes RATE_WIDTH steps
// per sample. One result may wait in the output register while the next sample is
// processed. Reset clears the DC, tap, last filter value, beat flag, count and period
// state and loads the registers with 20, 50, 1200.
// Top level: configuration registers, controller and datapath; uses hrd_pkg.
module pulse_oximeter_heart_rate_detector_top #(
    parameter int SAMPLE_WIDTH = hrd_pkg::SAMPLE_WIDTH_DEFAULT,
    parameter int COUNT_WIDTH  = hrd_pkg::COUNT_WIDTH_DEFAULT,
    parameter int S_TDATA_W    = ((SAMPLE_WIDTH + 7) / 8) * 8,
    parameter int M_TDATA_W    = ((hrd_pkg::RATE_WIDTH + 4 + SAMPLE_WIDTH + 2 + 7) / 8) * 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // ir_sample
    input  logic [S_TDATA_W-1:0]                s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // heart_rate, rate_valid, beat_ended, in_beat, strong_beat, filtered_value
    output logic [M_TDATA_W-1:0]                m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [hrd_pkg::CFG_ADDR_WIDTH-1:0]  cfg_addr,
    input  logic [hrd_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);

    logic [hrd_pkg::FALL_WIDTH-1:0]   fall_threshold_reg;
    logic [hrd_pkg::STRONG_WIDTH-1:0] strong_level_reg;
    logic [hrd_pkg::RATE_WIDTH-1:0]   rate_numerator_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fall_threshold_reg <= hrd_pkg::FALL_THRESHOLD_RESET;
            strong_level_reg   <= hrd_pkg::STRONG_LEVEL_RESET;
            rate_numerator_reg <= hrd_pkg::RATE_NUMERATOR_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (hrd_pkg::cfg_index_t'(cfg_addr))
                hrd_pkg::CFG_FALL_THRESHOLD:
                    fall_threshold_reg <= cfg_data[hrd_pkg::FALL_WIDTH-1:0];
                hrd_pkg::CFG_STRONG_LEVEL:
                    strong_level_reg   <= cfg_data[hrd_pkg::STRONG_WIDTH-1:0];
                hrd_pkg::CFG_RATE_NUMERATOR:
                    rate_numerator_reg <= cfg_data[hrd_pkg::RATE_WIDTH-1:0];
                default:
                begin
                    // Writes beyond the last register are dropped.
                end
            endcase
        end
    end

    hrd_pkg::hrd_cmd_t    cmd;
    hrd_pkg::hrd_status_t status;

    logic [hrd_pkg::RATE_WIDTH-1:0] heart_rate;
    logic                           rate_valid;
    logic                           beat_ended;
    logic                           in_beat;
    logic                           strong_beat;
    logic signed [SAMPLE_WIDTH+1:0] filtered_value;

    hrd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    hrd_datapath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .ir_sample      (s_tdata[SAMPLE_WIDTH-1:0]),
        .fall_threshold (fall_threshold_reg),
        .strong_level   (strong_level_reg),
        .rate_numerator (rate_numerator_reg),
        .heart_rate     (heart_rate),
        .rate_valid     (rate_valid),
        .beat_ended     (beat_ended),
        .in_beat        (in_beat),
        .strong_beat    (strong_beat),
        .filtered_value (filtered_value)
    );

    assign m_tdata = M_TDATA_W'({filtered_value, strong_beat, in_beat, beat_ended,
                                 rate_valid, heart_rate});

endmodule
